>>> rtl/irpcd_pkg.sv
// irpcd_pkg: shared types and constants of the ir pulse command decoder
// used by every module under rtl; depends on nothing else

package irpcd_pkg;

  localparam int unsigned MAX_INTERVALS = 50;
  localparam int unsigned COMMAND_BITS  = 8;

  localparam int unsigned TICKS_W   = 17;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BIT_IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [TICKS_W-1:0] ZERO_MIN_RESET = TICKS_W'(1000);
  localparam logic [TICKS_W-1:0] ZERO_MAX_RESET = TICKS_W'(1600);
  localparam logic [POS_W-1:0]   FIRST_POS_RESET = POS_W'(17);
  localparam logic [BYTE_W-1:0]  BIT_STORE_RESET = '1;

  // event kinds
  localparam logic CMD_EDGE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_POS = CFG_IDX_W'(2);

  typedef struct packed {
    logic [TICKS_W-1:0] zero_min;
    logic [TICKS_W-1:0] zero_max;
    logic [POS_W-1:0]   first_pos;
  } cfg_t;

endpackage

>>> rtl/irpcd_cfg_regs.sv
// irpcd_cfg_regs: configuration register file of the ir pulse command decoder
// depends on irpcd_pkg

module irpcd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [irpcd_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [irpcd_pkg::CFG_DAT_W-1:0] wr_data,
  output irpcd_pkg::cfg_t                cfg
);

  irpcd_pkg::cfg_t cfg_r;
  irpcd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        irpcd_pkg::REG_ZERO_MIN:  cfg_nxt.zero_min  = wr_data[irpcd_pkg::TICKS_W-1:0];
        irpcd_pkg::REG_ZERO_MAX:  cfg_nxt.zero_max  = wr_data[irpcd_pkg::TICKS_W-1:0];
        irpcd_pkg::REG_FIRST_POS: cfg_nxt.first_pos = wr_data[irpcd_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_min  <= irpcd_pkg::ZERO_MIN_RESET;
      cfg_r.zero_max  <= irpcd_pkg::ZERO_MAX_RESET;
      cfg_r.first_pos <= irpcd_pkg::FIRST_POS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/irpcd_frame_ctrl.sv
// irpcd_frame_ctrl: frame state, interval counter and command bit store
// depends on irpcd_pkg

module irpcd_frame_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  irpcd_pkg::cfg_t                 cfg,
  input  logic                            step_en,
  input  logic                            command,
  input  logic [irpcd_pkg::TICKS_W-1:0]   interval_ticks,
  output logic                            emit,
  output logic [irpcd_pkg::BYTE_W-1:0]    command_byte
);

  logic                          frame_active_r, frame_active_nxt;
  logic [irpcd_pkg::POS_W-1:0]   edge_index_r, edge_index_nxt;
  logic [irpcd_pkg::BYTE_W-1:0]  bit_store_r, bit_store_nxt;
  logic [irpcd_pkg::POS_W-1:0]   bit_offset;
  logic                          is_zero;

  assign is_zero = (interval_ticks >= cfg.zero_min) && (interval_ticks <= cfg.zero_max);
  assign bit_offset = edge_index_r - cfg.first_pos;

  // a timeout only produces a beat inside a frame
  assign emit         = (command == irpcd_pkg::CMD_TIMEOUT) && frame_active_r;
  assign command_byte = bit_store_r;

  always_comb begin
    frame_active_nxt = frame_active_r;
    edge_index_nxt   = edge_index_r;
    bit_store_nxt    = bit_store_r;
    if (step_en) begin
      if (command == irpcd_pkg::CMD_EDGE) begin
        if (!frame_active_r) begin
          frame_active_nxt = 1'b1;
        end else if (edge_index_r < irpcd_pkg::POS_W'(irpcd_pkg::MAX_INTERVALS)) begin
          edge_index_nxt = edge_index_r + irpcd_pkg::POS_W'(1);
          if ((edge_index_r >= cfg.first_pos) &&
              (bit_offset < irpcd_pkg::POS_W'(irpcd_pkg::COMMAND_BITS))) begin
            bit_store_nxt[bit_offset[irpcd_pkg::BIT_IDX_W-1:0]] = !is_zero;
          end
        end
      end else if (frame_active_r) begin
        frame_active_nxt = 1'b0;
        edge_index_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r <= 1'b0;
      edge_index_r   <= '0;
      bit_store_r    <= irpcd_pkg::BIT_STORE_RESET;
    end else begin
      frame_active_r <= frame_active_nxt;
      edge_index_r   <= edge_index_nxt;
      bit_store_r    <= bit_store_nxt;
    end
  end

endmodule

>>> rtl/ir_pulse_command_decoder_core.sv
// ir_pulse_command_decoder_core: top level; input register, frame control, output register
// depends on irpcd_pkg, irpcd_cfg_regs, irpcd_frame_ctrl
// timing: an accepted beat is held in the input register and processed from there; a frame's
//   result is loaded into the output register when its closing timeout is processed
// throughput: one input beat per cycle, limited only by the single output register
// reset: rst_n low clears frame state, edge count, registers to defaults, bit store to ones

module ir_pulse_command_decoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [irpcd_pkg::IN_TDATA_W-1:0]    in_tdata,   // [16:0] interval_ticks, rest zero
  input  logic                                in_tuser,   // [0] command
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [irpcd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [7:0] command_byte
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [irpcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irpcd_pkg::CFG_DAT_W-1:0]     cfg_data
);

  irpcd_pkg::cfg_t                 cfg;
  logic                            in_valid_r, in_valid_nxt;
  logic                            in_cmd_r;
  logic [irpcd_pkg::TICKS_W-1:0]   in_ticks_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [irpcd_pkg::BYTE_W-1:0]    out_byte_r;
  logic                            emit;
  logic [irpcd_pkg::BYTE_W-1:0]    command_byte;
  logic                            out_free;
  logic                            step_en;
  logic                            in_fire;

  assign cfg_ready = 1'b1;

  irpcd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  irpcd_frame_ctrl u_frame_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .step_en        (step_en),
    .command        (in_cmd_r),
    .interval_ticks (in_ticks_r),
    .emit           (emit),
    .command_byte   (command_byte)
  );

  // registered item proceeds unless it needs an output slot that is still taken
  assign out_free  = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && (!emit || out_free);
  assign in_tready = !in_valid_r || step_en;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (step_en && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_cmd_r   <= in_tuser;
      in_ticks_r <= in_tdata[irpcd_pkg::TICKS_W-1:0];
    end
    if (step_en && emit) begin
      out_byte_r <= command_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;

endmodule

>>> tb/ir_pulse_command_decoder_core_test.sv
// ir_pulse_command_decoder_core_test: self-checking bench for the ir command decoder core;
// predicts each command byte from the accepted edge and timeout beats and compares results
// depends on irpcd_pkg and ir_pulse_command_decoder_core

module ir_pulse_command_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [irpcd_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic                             in_tuser = irpcd_pkg::CMD_EDGE;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [irpcd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [irpcd_pkg::CFG_IDX_W-1:0]  cfg_index = irpcd_pkg::REG_ZERO_MIN;
  logic [irpcd_pkg::CFG_DAT_W-1:0]  cfg_data = '0;

  ir_pulse_command_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // decoder state as predicted from accepted beats
  logic [irpcd_pkg::TICKS_W-1:0] zero_min   = irpcd_pkg::ZERO_MIN_RESET;
  logic [irpcd_pkg::TICKS_W-1:0] zero_max   = irpcd_pkg::ZERO_MAX_RESET;
  int unsigned                   first_pos  = 32'(irpcd_pkg::FIRST_POS_RESET);
  logic                          frame_open = 1'b0;
  int unsigned                   edge_count = 0;
  logic [irpcd_pkg::BYTE_W-1:0]  cmd_bits   = irpcd_pkg::BIT_STORE_RESET;

  logic [irpcd_pkg::BYTE_W-1:0]  expected_bytes[$];
  logic [irpcd_pkg::BYTE_W-1:0]  want_byte;
  int                            errors = 0;
  int                            items_sent = 0;
  int                            phase_no = 0;
  int                            send_idle_pct = 25;
  int                            recv_stall_pct = 50;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400us;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("command_byte: no result expected, got %02h",
               out_tdata[irpcd_pkg::BYTE_W-1:0]);
        errors++;
      end else begin
        want_byte = expected_bytes.pop_front();
        if (out_tdata[irpcd_pkg::BYTE_W-1:0] !== want_byte) begin
          $error("command_byte mismatch: expected %02h, actual %02h",
                 want_byte, out_tdata[irpcd_pkg::BYTE_W-1:0]);
          errors++;
        end
      end
    end
  end

  function automatic logic [irpcd_pkg::TICKS_W-1:0] rand_ticks();
    return irpcd_pkg::TICKS_W'($urandom_range(17'h1ffff));
  endfunction

  function automatic void decode_event(input logic kind,
                                       input logic [irpcd_pkg::TICKS_W-1:0] ticks);
    int unsigned k;
    if (kind == irpcd_pkg::CMD_EDGE) begin
      if (!frame_open) begin
        frame_open = 1'b1;
      end else if (edge_count < irpcd_pkg::MAX_INTERVALS) begin
        if (edge_count >= first_pos) begin
          k = edge_count - first_pos;
          if (k < irpcd_pkg::COMMAND_BITS && k < irpcd_pkg::BYTE_W)
            cmd_bits[k] = !((ticks >= zero_min) && (ticks <= zero_max));
        end
        edge_count++;
      end
    end else if (frame_open) begin
      expected_bytes.push_back(cmd_bits);
      frame_open = 1'b0;
      edge_count = 0;
    end
  endfunction

  task automatic send_event(input logic kind, input logic [irpcd_pkg::TICKS_W-1:0] ticks);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= irpcd_pkg::IN_TDATA_W'(ticks);
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // a timeout outside a frame is ignored by the block
    if (kind == irpcd_pkg::CMD_EDGE || frame_open) items_sent++;
    decode_event(kind, ticks);
  endtask

  // input side goes quiet until every pending command byte has come out
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [irpcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [irpcd_pkg::CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      irpcd_pkg::REG_ZERO_MIN:  zero_min = value[irpcd_pkg::TICKS_W-1:0];
      irpcd_pkg::REG_ZERO_MAX:  zero_max = value[irpcd_pkg::TICKS_W-1:0];
      irpcd_pkg::REG_FIRST_POS: first_pos = 32'(value[irpcd_pkg::POS_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [irpcd_pkg::TICKS_W-1:0] lo,
                              input logic [irpcd_pkg::TICKS_W-1:0] hi,
                              input logic [irpcd_pkg::POS_W-1:0] pos);
    wait_results_drained();
    write_reg(irpcd_pkg::REG_ZERO_MIN, irpcd_pkg::CFG_DAT_W'(lo));
    write_reg(irpcd_pkg::REG_ZERO_MAX, irpcd_pkg::CFG_DAT_W'(hi));
    write_reg(irpcd_pkg::REG_FIRST_POS, irpcd_pkg::CFG_DAT_W'(pos));
  endtask

  // interval for a command position: window edges, just outside, inside, nec one, anything
  function automatic logic [irpcd_pkg::TICKS_W-1:0] pick_bit_ticks();
    case ($urandom_range(7))
      0: return zero_min;
      1: return zero_max;
      2: return zero_min - 1'b1;
      3: return zero_max + 1'b1;
      4, 5: begin
        if (zero_min <= zero_max)
          return irpcd_pkg::TICKS_W'($urandom_range(zero_max, zero_min));
        return rand_ticks();
      end
      6: return irpcd_pkg::TICKS_W'(2250);
      default: return rand_ticks();
    endcase
  endfunction

  task automatic send_frame();
    int n_edges;
    int style;
    style = $urandom_range(99);
    if (style < 72) n_edges = first_pos + irpcd_pkg::COMMAND_BITS;
    else if (style < 86) n_edges = $urandom_range(first_pos + irpcd_pkg::COMMAND_BITS);
    else if (style < 94) n_edges = first_pos + irpcd_pkg::COMMAND_BITS + $urandom_range(4);
    else n_edges = irpcd_pkg::MAX_INTERVALS + $urandom_range(8);
    send_event(irpcd_pkg::CMD_EDGE, rand_ticks());
    for (int i = 0; i < n_edges; i++) begin
      if (i >= first_pos && i < first_pos + irpcd_pkg::COMMAND_BITS)
        send_event(irpcd_pkg::CMD_EDGE, pick_bit_ticks());
      else
        send_event(irpcd_pkg::CMD_EDGE, rand_ticks());
    end
    send_event(irpcd_pkg::CMD_TIMEOUT, rand_ticks());
  endtask

  // stray events: timeouts outside frames, lone edges, broken frames
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(1)) send_event(irpcd_pkg::CMD_TIMEOUT, rand_ticks());
      else send_event(irpcd_pkg::CMD_EDGE, pick_bit_ticks());
    end
  endtask

  task automatic test_timeout_outside_frame();
    send_event(irpcd_pkg::CMD_TIMEOUT, '0);
    send_event(irpcd_pkg::CMD_TIMEOUT, '1);
  endtask

  task automatic test_empty_frame();
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(13500));
    send_event(irpcd_pkg::CMD_TIMEOUT, '0);
  endtask

  task automatic test_zero_window_edges();
    wait_results_drained();
    write_reg(irpcd_pkg::REG_FIRST_POS, irpcd_pkg::CFG_DAT_W'(0));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(13500));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(1000));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(1600));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(999));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(1601));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(0));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(17'h1ffff));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(1300));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(2250));
    send_event(irpcd_pkg::CMD_TIMEOUT, irpcd_pkg::TICKS_W'(17'h15555));
  endtask

  task automatic test_partial_frame();
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(17'h0aaaa));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(2250));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(1125));
    send_event(irpcd_pkg::CMD_EDGE, irpcd_pkg::TICKS_W'(2250));
    send_event(irpcd_pkg::CMD_TIMEOUT, '0);
  endtask

  task automatic test_random_frames(input int budget);
    int stop_at;
    logic [irpcd_pkg::TICKS_W-1:0] lo;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      case (phase_no % 8)
        0: apply_config(irpcd_pkg::ZERO_MIN_RESET, irpcd_pkg::ZERO_MAX_RESET,
                        irpcd_pkg::FIRST_POS_RESET);
        1: apply_config('0, '1, irpcd_pkg::POS_W'(0));
        2: apply_config('1, '0, irpcd_pkg::POS_W'(42));
        3: apply_config(irpcd_pkg::TICKS_W'(500), irpcd_pkg::TICKS_W'(500),
                        irpcd_pkg::POS_W'(3));
        // upper command bits sit beyond the maximum interval count
        4: apply_config(irpcd_pkg::TICKS_W'(1), irpcd_pkg::TICKS_W'(1),
                        irpcd_pkg::POS_W'(47));
        5: apply_config(irpcd_pkg::TICKS_W'(1), irpcd_pkg::TICKS_W'(1), '1);
        6: begin
          lo = irpcd_pkg::TICKS_W'($urandom_range(2000));
          apply_config(lo, lo + irpcd_pkg::TICKS_W'($urandom_range(1500)),
                       irpcd_pkg::POS_W'($urandom_range(12)));
        end
        default: apply_config(rand_ticks(), rand_ticks(),
                              irpcd_pkg::POS_W'($urandom_range(42)));
      endcase
      phase_no++;
      repeat (3) begin
        if (items_sent < stop_at) begin
          if ($urandom_range(99) < 85) send_frame();
          else send_noise();
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_timeout_outside_frame();
    test_empty_frame();
    test_zero_window_edges();
    test_partial_frame();

    test_random_frames(300);
    send_idle_pct  = 50;
    recv_stall_pct = 25;
    test_random_frames(300);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_frames(300);

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
